[rtl/assert_macros.svh]
// assertion macros shared by the fragment reassembly deframer rtl
// expects clk and rst_n in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define FRD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked at every clock edge outside reset
`define FRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/frd_pkg.sv]
// types and constants of the fragment reassembly deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frd_pkg;

    // header layout: three little-endian words, twelve bytes
    localparam logic [3:0] HEADER_BYTES    = 4'd12;
    localparam logic [3:0] IDX_FRAGS_LAST  = 4'd3;
    localparam logic [3:0] IDX_TOTAL_LAST  = 4'd7;
    localparam logic [3:0] IDX_PLEN_LAST   = 4'd11;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_COUNTDOWN = 3'd1;
    localparam logic [2:0] ERR_TOTAL     = 3'd2;
    localparam logic [2:0] ERR_SHORT     = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;

    // one received fragment byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       frag_end;
    } frd_in_t;

    // one result per received byte
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        logic        message_done;
        logic [31:0] message_length;
        logic [2:0]  error_code;
    } frd_out_t;

endpackage

`default_nettype wire

[rtl/frd_stream_if.sv]
// valid/ready channel carrying one payload item per handshake
// payload type is given by the instantiating module
`timescale 1ns / 1ps
`default_nettype none

interface frd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/frd_core.sv]
// deframer state and per-byte decision logic
// depends on frd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frd_core
    import frd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire frd_in_t  item,
    output frd_out_t      result
);

    logic [3:0]  header_index_reg, header_index_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [31:0] frags_left_reg, frags_left_next;
    logic [31:0] msg_total_reg, msg_total_next;
    logic [31:0] frag_len_reg, frag_len_next;
    logic [31:0] frag_count_reg, frag_count_next;
    logic [31:0] msg_pos_reg, msg_pos_next;
    logic        awaiting_reg, awaiting_next;
    logic        discarding_reg, discarding_next;

    // next state and result for the byte on the input
    always_comb
    begin
        logic [2:0]  err;
        logic [31:0] ws;
        logic [3:0]  hi_inc;

        header_index_next = header_index_reg;
        word_shift_next   = word_shift_reg;
        frags_left_next   = frags_left_reg;
        msg_total_next    = msg_total_reg;
        frag_len_next     = frag_len_reg;
        frag_count_next   = frag_count_reg;
        msg_pos_next      = msg_pos_reg;
        awaiting_next     = awaiting_reg;
        discarding_next   = discarding_reg;
        result            = '0;
        err               = ERR_NONE;
        ws                = {item.in_byte, word_shift_reg[31:8]};
        hi_inc            = header_index_reg + 4'd1;

        if (discarding_reg)
        begin
            // drop the rest of a failed fragment
            if (item.frag_end)
            begin
                discarding_next   = 1'b0;
                header_index_next = '0;
            end
        end
        else
        begin
            if (header_index_reg < HEADER_BYTES)
            begin
                // header byte
                word_shift_next   = ws;
                header_index_next = hi_inc;
                if (header_index_reg == IDX_FRAGS_LAST)
                begin
                    if (awaiting_reg || ws == frags_left_reg - 32'd1)
                        frags_left_next = ws;
                    else
                        err = ERR_COUNTDOWN;
                end
                else if (header_index_reg == IDX_TOTAL_LAST)
                begin
                    if (awaiting_reg)
                    begin
                        msg_total_next = ws;
                        msg_pos_next   = '0;
                    end
                    else if (ws != msg_total_reg)
                        err = ERR_TOTAL;
                end
                else if (header_index_reg == IDX_PLEN_LAST)
                begin
                    frag_len_next   = ws;
                    frag_count_next = '0;
                    awaiting_next   = 1'b0;
                end
                if (err == ERR_NONE && item.frag_end &&
                    (hi_inc < HEADER_BYTES || frag_len_next != '0))
                    err = ERR_SHORT;
            end
            else
            begin
                // payload byte, extra bytes past the declared length ignored
                if (frag_count_reg < frag_len_reg)
                begin
                    if (msg_pos_reg >= msg_total_reg)
                        err = ERR_OVERRUN;
                    else
                    begin
                        result.payload_valid  = 1'b1;
                        result.payload_byte   = item.in_byte;
                        result.payload_offset = msg_pos_reg;
                        msg_pos_next          = msg_pos_reg + 32'd1;
                        frag_count_next       = frag_count_reg + 32'd1;
                    end
                end
                if (err == ERR_NONE && item.frag_end && frag_count_next < frag_len_reg)
                    err = ERR_SHORT;
            end

            // error restarts the message, fragment end may close it
            if (err != ERR_NONE)
            begin
                result.payload_valid  = 1'b0;
                result.payload_byte   = '0;
                result.payload_offset = '0;
                header_index_next     = '0;
                frag_len_next         = '0;
                frag_count_next       = '0;
                msg_pos_next          = '0;
                awaiting_next         = 1'b1;
                discarding_next       = !item.frag_end;
            end
            else if (item.frag_end)
            begin
                if (frags_left_next == '0)
                begin
                    result.message_done   = 1'b1;
                    result.message_length = msg_total_next;
                    frag_len_next         = '0;
                    frag_count_next       = '0;
                    msg_pos_next          = '0;
                    awaiting_next         = 1'b1;
                end
                header_index_next = '0;
            end
        end
        result.error_code = err;
    end

    // state registers, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= '0;
            word_shift_reg   <= '0;
            frags_left_reg   <= '0;
            msg_total_reg    <= '0;
            frag_len_reg     <= '0;
            frag_count_reg   <= '0;
            msg_pos_reg      <= '0;
            awaiting_reg     <= 1'b1;
            discarding_reg   <= 1'b0;
        end
        else if (step)
        begin
            header_index_reg <= header_index_next;
            word_shift_reg   <= word_shift_next;
            frags_left_reg   <= frags_left_next;
            msg_total_reg    <= msg_total_next;
            frag_len_reg     <= frag_len_next;
            frag_count_reg   <= frag_count_next;
            msg_pos_reg      <= msg_pos_next;
            awaiting_reg     <= awaiting_next;
            discarding_reg   <= discarding_next;
        end
    end

    // checks
    `FRD_ASSERT(a_hdr_index_range, header_index_reg <= HEADER_BYTES, "header index past header")
    `FRD_ASSERT_IMP(a_discard_restarted, discarding_reg, (header_index_reg == '0) && awaiting_reg,
        "discarding without a restarted message")
    `FRD_ASSERT_IMP(a_err_no_output, step && (result.error_code != ERR_NONE),
        !result.payload_valid && !result.message_done, "error item carries payload or done")

endmodule

`default_nettype wire

[rtl/frd_out_reg.sv]
// result register between the decision logic and the output channel
// depends on frd_pkg, frd_stream_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frd_out_reg
    import frd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire frd_out_t   result,
    output logic            space,
    frd_stream_if.source    msg_out
);

    logic     valid_reg;
    frd_out_t data_reg;

    // room for a new item when empty or when the held one leaves now
    assign space = !valid_reg || msg_out.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (msg_out.ready)
            valid_reg <= 1'b0;
    end

    // payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign msg_out.valid   = valid_reg;
    assign msg_out.payload = data_reg;

    // checks
    `FRD_ASSERT_IMP(a_no_space_when_stalled, !space, valid_reg && !msg_out.ready,
        "upstream blocked without a stalled item")
    `FRD_ASSERT_IMP(a_load_only_with_space, load, space, "item loaded over a held result")

endmodule

`default_nettype wire

[rtl/fragment_reassembly_deframer_unit.sv]
// Fragment reassembly deframer, top level.
// Channel frag_in (sink) takes one fragment byte per item: in_byte and frag_end,
// the latter marking the last byte of a fragment. Each fragment starts with a
// 12-byte header (fragments to come, message total, payload length, all
// little-endian 32-bit words) followed by its payload.
// Channel msg_out (source) gives exactly one result item per input item:
// payload byte with its message offset, message done with the total length,
// or an error code (countdown, total changed, fragment short, overrun), or none.
// A result is registered and offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the state update is a single pass of compares
// and 32-bit counter increments, so a byte can follow in every unstalled cycle.
// Stall: a result waits in the output register; frag_in.ready stays high while
// that register is empty or is being emptied in the same cycle, so a stall on
// msg_out holds off frag_in only while a result is actually waiting.
// Reset (rst_n, asynchronous, active low): output empty, header counter at
// zero, waiting for the first fragment of a message.
// depends on frd_pkg, frd_stream_if, frd_core, frd_out_reg
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_deframer_unit
    import frd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    frd_stream_if.sink    frag_in,
    frd_stream_if.source  msg_out
);

    logic     accept;
    logic     space;
    frd_in_t  item;
    frd_out_t result;

    // input handshake
    assign frag_in.ready = space;
    assign accept        = frag_in.valid && space;
    assign item          = frag_in.payload;

    // per-byte decision and state
    frd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .item   (item),
        .result (result)
    );

    // result register
    frd_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .result  (result),
        .space   (space),
        .msg_out (msg_out)
    );

endmodule

`default_nettype wire
